FILE: rtl/gasp_pkg.sv
// Package for the grid A* path search core: request/result structs, codes and constants.
// Used by every module in the rtl folder; depends on nothing.
package gasp_pkg;

  localparam int GridWidthDef  = 64;
  localparam int GridHeightDef = 64;
  localparam int CoordW        = 6;
  localparam int IdxW          = 12;
  localparam int CostW         = 16;
  localparam int FW            = 20;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_SRCH  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] HEUR_NONE = 2'd0;
  localparam logic [1:0] HEUR_MAN  = 2'd1;
  localparam logic [1:0] HEUR_DIAG = 2'd2;
  localparam logic [1:0] HEUR_EUC  = 2'd3;

  localparam logic [CostW-1:0] Unreached = 16'hFFFF;

  typedef struct packed {
    logic [1:0]        func;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic              walkable;
    logic [CoordW-1:0] target_x;
    logic [CoordW-1:0] target_y;
    logic [IdxW-1:0]   path_index;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [IdxW-1:0]   path_length;
    logic [CoordW-1:0] step_x;
    logic [CoordW-1:0] step_y;
    logic              step_valid;
  } res_t;

endpackage

FILE: rtl/gasp_heur.sv
// Heuristic unit for the grid A* path search core: one distance estimate per start pulse.
// Depends on gasp_pkg; the Euclidean form uses a two-bit-per-cycle square root.
module gasp_heur (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [1:0]                 mode,
  input  logic [7:0]                 dx,
  input  logic [7:0]                 dy,
  output logic                       done,
  output logic [gasp_pkg::FW-1:0]    h
);

  localparam int FW = gasp_pkg::FW;

  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [23:0] rad_r, rad_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [12:0] root_r, root_nxt;
  logic [FW-1:0] h_r, h_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  mn;
  logic [16:0] sq;
  logic [25:0] trial;
  logic [25:0] rem_sh;

  assign mn = (dx < dy) ? dx : dy;
  assign sq = 17'(dx * dx) + 17'(dy * dy);
  assign rem_sh = {rem_r[23:0], rad_r[23:22]};
  assign trial  = {11'd0, root_r, 2'b01};

  // Direct forms register h and done straight from the start pulse; the square root walks 12 digit pairs.
  always_comb begin
    cnt_nxt = cnt_r; busy_nxt = busy_r; rad_nxt = rad_r; rem_nxt = rem_r;
    root_nxt = root_r; h_nxt = h_r; done_nxt = 1'b0;
    if (start) begin
      case (mode)
        gasp_pkg::HEUR_MAN: begin
          h_nxt = FW'(10 * (32'(dx) + 32'(dy))); done_nxt = 1'b1;
        end
        gasp_pkg::HEUR_DIAG: begin
          h_nxt = FW'(10 * (32'(dx) + 32'(dy)) - 6 * 32'(mn)); done_nxt = 1'b1;
        end
        gasp_pkg::HEUR_EUC: begin
          rad_nxt = 24'(100 * 32'(sq)); rem_nxt = '0; root_nxt = '0;
          cnt_nxt = '0; busy_nxt = 1'b1;
        end
        default: begin
          h_nxt = '0; done_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      rad_nxt = {rad_r[21:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt = rem_sh - trial; root_nxt = {root_r[11:0], 1'b1};
      end else begin
        rem_nxt = rem_sh; root_nxt = {root_r[11:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd11) begin
        busy_nxt = 1'b0; cnt_nxt = '0;
        // Round half up: remainder above root means the fraction is at least one half.
        if (rem_nxt > {13'd0, root_nxt}) h_nxt = FW'(root_nxt) + FW'(1);
        else h_nxt = FW'(root_nxt);
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt; done_r <= done_nxt;
    end
    rad_r <= rad_nxt; rem_r <= rem_nxt; root_r <= root_nxt; h_r <= h_nxt;
  end

  assign done = done_r;
  assign h    = h_r;

endmodule

FILE: rtl/grid_astar_path_search_core.sv
// Grid A* path search core: top level with the map, closed, cost, link and path
// memories and the search sequencer. Depends on gasp_pkg and gasp_heur.
//
// One request is taken at a time and gives one result. A map write passes through
// S_WR and then, like a path read, S_RD and S_RDW. Cells are addressed as {y, x},
// so the cell memories hold 2**(clog2(GRID_WIDTH)+clog2(GRID_HEIGHT)) entries,
// which equals GRID_WIDTH*GRID_HEIGHT for power-of-two sizes. After reset a
// clearing pass over every entry blocks the map before the first request. A search
// first clears the closed marks and costs (one entry per cycle), then runs rounds:
// each round scans every cell with one read of the cell memories and, for open
// cells, a heuristic, then closes the best cell and relaxes its eight neighbors.
// A search ends with two walks of the path through the link memory, one to count
// its length and one to store its steps.
module grid_astar_path_search_core #(
  parameter int GRID_WIDTH  = gasp_pkg::GridWidthDef,
  parameter int GRID_HEIGHT = gasp_pkg::GridHeightDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gasp_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gasp_pkg::res_t  out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_wdata
);

  localparam int Cells = GRID_WIDTH * GRID_HEIGHT;
  localparam int XW    = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
  localparam int YW    = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int AW    = XW + YW;
  localparam int Depth = 1 << AW;
  localparam int CW    = AW + 1;
  localparam int IW    = gasp_pkg::IdxW;
  localparam int FW    = gasp_pkg::FW;
  localparam int CstW  = gasp_pkg::CostW;

  localparam logic [4:0] S_INIT = 5'd0,  S_IDLE = 5'd1,  S_WR    = 5'd2,
                         S_RD   = 5'd3,  S_RDW  = 5'd4,  S_OUT   = 5'd5,
                         S_CLR  = 5'd6,  S_SCRD = 5'd7,  S_SCEV  = 5'd8,
                         S_SCH  = 5'd9,  S_PICK = 5'd10, S_NBA   = 5'd11,
                         S_NBR  = 5'd12, S_NBW  = 5'd13, S_CNT   = 5'd14,
                         S_CNTW = 5'd15, S_STO  = 5'd16, S_STOW  = 5'd17,
                         S_FAIL = 5'd18, S_CRD  = 5'd19;

  // Memories: cell address is {y, x}.
  logic             walk_mem [Depth];
  logic             closed_mem [Depth];
  logic [CstW-1:0]  cost_mem [Depth];
  logic [AW-1:0]    link_mem [Depth];
  logic [AW-1:0]    path_mem [1 << IW];

  logic [4:0]       st_r, st_nxt;
  logic [1:0]       hmode_r;
  gasp_pkg::req_t   req_r, req_nxt;
  gasp_pkg::res_t   res_r, res_nxt;
  logic [IW-1:0]    len_r, len_nxt;
  logic             fnd_r, fnd_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic [XW-1:0]    sx_r, sx_nxt;
  logic [YW-1:0]    sy_r, sy_nxt;
  logic             have_r, have_nxt;
  logic [FW-1:0]    best_r, best_nxt;
  logic [AW-1:0]    bc_r, bc_nxt;
  logic [CstW-1:0]  bcost_r, bcost_nxt;
  logic [CstW-1:0]  gcost_r, gcost_nxt;
  logic [3:0]       nb_r, nb_nxt;
  logic [AW-1:0]    cur_r, cur_nxt;
  logic [IW:0]      cnt_r, cnt_nxt;
  logic             tclosed_r, tclosed_nxt;

  // Memory port controls.
  logic             w_we, c_we, k_we, l_we, p_we;
  logic [AW-1:0]    w_wa, c_wa, k_wa, l_wa, ra;
  logic             w_wd, c_wd;
  logic [CstW-1:0]  k_wd;
  logic [AW-1:0]    l_wd;
  logic [IW-1:0]    p_wa, p_ra;
  logic [AW-1:0]    p_wd;
  logic             w_q, c_q;
  logic [CstW-1:0]  k_q;
  logic [AW-1:0]    l_q, p_q;

  logic             h_start, h_done;
  logic [FW-1:0]    h_val;
  logic [7:0]       dx, dy;
  logic [AW-1:0]    start_a, targ_a;
  logic             in_grid;
  logic signed [9:0] nxs, nys;
  logic [1:0]       ox, oy;
  logic [16:0]      ncost;
  logic [FW-1:0]    f_val;

  always_ff @(posedge clk) begin
    if (w_we) walk_mem[w_wa] <= w_wd;
    if (c_we) closed_mem[c_wa] <= c_wd;
    if (k_we) cost_mem[k_wa] <= k_wd;
    if (l_we) link_mem[l_wa] <= l_wd;
    if (p_we) path_mem[p_wa] <= p_wd;
    w_q <= walk_mem[ra];
    c_q <= closed_mem[ra];
    k_q <= cost_mem[ra];
    l_q <= link_mem[ra];
    p_q <= path_mem[p_ra];
  end

  assign in_grid = (32'(req_r.cell_x) < GRID_WIDTH) && (32'(req_r.cell_y) < GRID_HEIGHT) &&
                   (32'(req_r.target_x) < GRID_WIDTH) && (32'(req_r.target_y) < GRID_HEIGHT);
  assign start_a = {YW'(req_r.cell_y), XW'(req_r.cell_x)};
  assign targ_a  = {YW'(req_r.target_y), XW'(req_r.target_x)};

  // Distance from the scanned cell to the target.
  always_comb begin
    logic [7:0] cx, cy, tx, ty;
    cx = 8'(sx_r); cy = 8'(sy_r); tx = 8'(req_r.target_x); ty = 8'(req_r.target_y);
    dx = (cx > tx) ? cx - tx : tx - cx;
    dy = (cy > ty) ? cy - ty : ty - cy;
  end

  gasp_heur u_heur (
    .clk(clk), .rst_n(rst_n), .start(h_start), .mode(hmode_r),
    .dx(dx), .dy(dy), .done(h_done), .h(h_val)
  );

  // Neighbor offsets: nb counts x offset outer, y offset inner, center skipped.
  always_comb begin
    case (nb_r)
      4'd0: begin ox = 2'd0; oy = 2'd0; end
      4'd1: begin ox = 2'd0; oy = 2'd1; end
      4'd2: begin ox = 2'd0; oy = 2'd2; end
      4'd3: begin ox = 2'd1; oy = 2'd0; end
      4'd4: begin ox = 2'd1; oy = 2'd2; end
      4'd5: begin ox = 2'd2; oy = 2'd0; end
      4'd6: begin ox = 2'd2; oy = 2'd1; end
      4'd7: begin ox = 2'd2; oy = 2'd2; end
      default: begin ox = 2'd0; oy = 2'd0; end
    endcase
    nxs = 10'(bc_r[XW-1:0]) + 10'(ox) - 10'sd1;
    nys = 10'(bc_r[AW-1:XW]) + 10'(oy) - 10'sd1;
  end

  assign ncost = 17'(bcost_r) + ((ox == 2'd1 || oy == 2'd1) ? 17'd10 : 17'd14);
  assign f_val = FW'(gcost_r) + h_val;

  // Sequencer.
  always_comb begin
    st_nxt = st_r; req_nxt = req_r; res_nxt = res_r; len_nxt = len_r; fnd_nxt = fnd_r;
    ptr_nxt = ptr_r; sx_nxt = sx_r; sy_nxt = sy_r; have_nxt = have_r; best_nxt = best_r;
    bc_nxt = bc_r; bcost_nxt = bcost_r; gcost_nxt = gcost_r; nb_nxt = nb_r;
    cur_nxt = cur_r; cnt_nxt = cnt_r; tclosed_nxt = tclosed_r;
    w_we = 1'b0; c_we = 1'b0; k_we = 1'b0; l_we = 1'b0; p_we = 1'b0;
    w_wa = AW'(ptr_r); c_wa = AW'(ptr_r); k_wa = AW'(ptr_r); l_wa = cur_r;
    w_wd = 1'b0; c_wd = 1'b0; k_wd = gasp_pkg::Unreached; l_wd = bc_r;
    p_wa = cnt_r[IW-1:0]; p_wd = cur_r; p_ra = req_r.path_index;
    ra = {sy_r, sx_r}; h_start = 1'b0;
    case (st_r)
      S_INIT: begin
        w_we = 1'b1;
        ptr_nxt = ptr_r + CW'(1);
        if (ptr_r == CW'(Depth - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          case (in_data.func)
            gasp_pkg::FUNC_WRITE: st_nxt = S_WR;
            gasp_pkg::FUNC_SRCH:  st_nxt = S_CRD;
            default:              st_nxt = S_RD;
          endcase
        end
      end
      S_WR: begin
        w_wa = {YW'(req_r.cell_y), XW'(req_r.cell_x)};
        w_wd = req_r.walkable;
        w_we = (32'(req_r.cell_x) < GRID_WIDTH) && (32'(req_r.cell_y) < GRID_HEIGHT);
        st_nxt = S_RD;
      end
      S_CRD: begin
        fnd_nxt = 1'b0; len_nxt = '0;
        if (!in_grid) st_nxt = S_RD;
        else if (start_a == targ_a) begin
          fnd_nxt = 1'b1; st_nxt = S_RD;
        end else begin
          ptr_nxt = '0; st_nxt = S_CLR; tclosed_nxt = 1'b0;
        end
      end
      S_CLR: begin
        c_we = 1'b1; k_we = 1'b1;
        k_wd = (AW'(ptr_r) == start_a) ? '0 : gasp_pkg::Unreached;
        ptr_nxt = ptr_r + CW'(1);
        if (ptr_r == CW'(Depth - 1)) begin
          sx_nxt = '0; sy_nxt = '0; have_nxt = 1'b0; st_nxt = S_SCRD;
        end
      end
      // Scan: read cell, then evaluate.
      S_SCRD: begin
        st_nxt = S_SCEV;
      end
      S_SCEV: begin
        gcost_nxt = k_q;
        if (!c_q && w_q && k_q != gasp_pkg::Unreached) begin
          h_start = 1'b1; st_nxt = S_SCH;
        end else st_nxt = S_PICK;
      end
      S_SCH: begin
        if (h_done) begin
          if (!have_r || f_val < best_r) begin
            have_nxt = 1'b1; best_nxt = f_val; bc_nxt = {sy_r, sx_r}; bcost_nxt = gcost_r;
          end
          st_nxt = S_PICK;
        end
      end
      // Advance column-major; at the end close the best cell, or fail if there is none.
      S_PICK: begin
        if (32'(sy_r) != GRID_HEIGHT - 1) begin
          sy_nxt = sy_r + YW'(1); st_nxt = S_SCRD;
        end else if (32'(sx_r) != GRID_WIDTH - 1) begin
          sy_nxt = '0; sx_nxt = sx_r + XW'(1); st_nxt = S_SCRD;
        end else if (!have_r) st_nxt = S_FAIL;
        else begin
          c_wa = bc_r; c_wd = 1'b1; c_we = 1'b1;
          if (bc_r == targ_a) tclosed_nxt = 1'b1;
          nb_nxt = '0; st_nxt = S_NBA;
        end
      end
      S_NBA: begin
        if (nxs < 0 || nys < 0 || 32'(nxs) >= GRID_WIDTH || 32'(nys) >= GRID_HEIGHT) begin
          st_nxt = S_NBW;
        end else begin
          ra = {YW'(nys), XW'(nxs)}; cur_nxt = {YW'(nys), XW'(nxs)}; st_nxt = S_NBR;
        end
      end
      S_NBR: begin
        ra = cur_r;
        if (w_q && !c_q) begin
          if (ncost >= 17'(gasp_pkg::Unreached)) begin
            if (gasp_pkg::Unreached < k_q) begin
              k_we = 1'b1; k_wa = cur_r; l_we = 1'b1;
            end
          end else if (16'(ncost) < k_q) begin
            k_we = 1'b1; k_wa = cur_r; k_wd = 16'(ncost); l_we = 1'b1;
          end
        end
        st_nxt = S_NBW;
      end
      S_NBW: begin
        nb_nxt = nb_r + 4'd1;
        if (nb_r == 4'd7) begin
          sx_nxt = '0; sy_nxt = '0; have_nxt = 1'b0;
          if (tclosed_r) begin
            cur_nxt = targ_a; cnt_nxt = '0; st_nxt = S_CNT;
          end else st_nxt = S_SCRD;
        end else st_nxt = S_NBA;
      end
      // Count path length through the links.
      S_CNT: begin
        ra = cur_r;
        if (cur_r == start_a) begin
          if (cnt_r > (IW+1)'(4095)) st_nxt = S_FAIL;
          else begin
            len_nxt = cnt_r[IW-1:0]; cur_nxt = targ_a; st_nxt = S_STO;
          end
        end else if (32'(cnt_r) >= Cells || cnt_r[IW]) st_nxt = S_FAIL;
        else st_nxt = S_CNTW;
      end
      S_CNTW: begin
        ra = cur_r; cur_nxt = l_q; cnt_nxt = cnt_r + (IW+1)'(1); st_nxt = S_CNT;
      end
      S_STO: begin
        ra = cur_r;
        if (cnt_r == '0) begin
          fnd_nxt = 1'b1; st_nxt = S_RD;
        end else begin
          p_we = 1'b1; p_wa = IW'(cnt_r - (IW+1)'(1)); cnt_nxt = cnt_r - (IW+1)'(1);
          st_nxt = S_STOW;
        end
      end
      S_STOW: begin
        ra = cur_r; cur_nxt = l_q; st_nxt = S_STO;
      end
      S_FAIL: begin
        fnd_nxt = 1'b0; len_nxt = '0; st_nxt = S_RD;
      end
      S_RD: st_nxt = S_RDW;
      S_RDW: begin
        res_nxt.found = fnd_r;
        res_nxt.path_length = len_r;
        res_nxt.step_valid = fnd_r && (req_r.path_index < len_r);
        res_nxt.step_x = res_nxt.step_valid ? 6'(p_q[XW-1:0]) : '0;
        res_nxt.step_y = res_nxt.step_valid ? 6'(p_q[AW-1:XW]) : '0;
        st_nxt = S_OUT;
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; ptr_r <= '0; hmode_r <= gasp_pkg::HEUR_MAN;
      len_r <= '0; fnd_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ptr_r <= ptr_nxt; len_r <= len_nxt; fnd_r <= fnd_nxt;
      if (cfg_we) hmode_r <= cfg_wdata;
    end
    req_r <= req_nxt; res_r <= res_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt;
    have_r <= have_nxt; best_r <= best_nxt; bc_r <= bc_nxt; bcost_r <= bcost_nxt;
    gcost_r <= gcost_nxt; nb_r <= nb_nxt; cur_r <= cur_nxt; cnt_r <= cnt_nxt;
    tclosed_r <= tclosed_nxt;
  end

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_data  = res_r;

  // A request and a result are never pending at the same time.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("request and result overlap");
  // A result that claims a step must come from a found path.
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.step_valid || out_data.found))
    else $error("step without found path");
  // A stored length is zero whenever no path is found.
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.path_length == '0))
    else $error("length without path");

endmodule

FILE: sim/gasp_route_checker.sv
`timescale 1ns / 1ps
// Checker for the grid A* path search core: watches the request, result and
// register ports, keeps its own map and search state, and compares every result.
// Depends on gasp_pkg for the payload structs and the operation and mode codes.
module gasp_route_checker #(
  parameter int GW = 8,
  parameter int GH = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  gasp_pkg::req_t  in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  gasp_pkg::res_t  out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_wdata,
  output int              pending,
  output int              fail_count
);

  localparam int CELLS = GW * GH;
  localparam int unsigned NoCost = 32'd65535;

  // Model state of the block.
  bit               walk_bit [CELLS];
  bit               done_bit [CELLS];
  int unsigned      g_cost   [CELLS];
  int unsigned      parent   [CELLS];
  int unsigned      route    [4096];
  int unsigned      route_len;
  bit               route_ok;
  logic [1:0]       heur_sel;

  gasp_pkg::res_t   want_q[$];

  assign pending = want_q.size();

  // Estimated remaining cost from one cell to the target.
  function automatic int unsigned dist_est(int unsigned x, int unsigned y,
                                           int unsigned tx, int unsigned ty);
    int unsigned dx, dy, mn, n, r;
    dx = (x > tx) ? x - tx : tx - x;
    dy = (y > ty) ? y - ty : ty - y;
    mn = (dx < dy) ? dx : dy;
    case (heur_sel)
      gasp_pkg::HEUR_MAN:  return 10 * (dx + dy);
      gasp_pkg::HEUR_DIAG: return 10 * (dx + dy) - 6 * mn;
      gasp_pkg::HEUR_EUC: begin
        n = 100 * (dx * dx + dy * dy);
        r = 0;
        while ((r + 1) * (r + 1) <= n) r++;
        if (n - r * r > r) r++;
        return r;
      end
      default:   return 0;
    endcase
  endfunction

  // Full search from start to target; leaves the route and its length.
  function automatic void find_route(int unsigned sx, int unsigned sy,
                                     int unsigned tx, int unsigned ty);
    int unsigned start, target, cur, count, best, bx, by, f, c, nc, n, i;
    bit have;
    int nx, ny;
    route_ok  = 0;
    route_len = 0;
    if (sx >= GW || sy >= GH || tx >= GW || ty >= GH) return;
    if (sx == tx && sy == ty) begin
      route_ok = 1;
      return;
    end
    start  = sy * GW + sx;
    target = ty * GW + tx;
    for (int k = 0; k < CELLS; k++) begin
      done_bit[k] = 0;
      g_cost[k]   = NoCost;
      parent[k]   = 0;
    end
    g_cost[start] = 0;
    for (int rnd = 0; rnd < CELLS && !done_bit[target]; rnd++) begin
      have = 0;
      best = 0;
      bx = 0;
      by = 0;
      // Column-major scan; strict compare keeps the first cell on a tie.
      for (int x = 0; x < GW; x++) begin
        for (int y = 0; y < GH; y++) begin
          i = y * GW + x;
          if (done_bit[i] || !walk_bit[i] || g_cost[i] == NoCost) continue;
          f = g_cost[i] + dist_est(x, y, tx, ty);
          if (!have || f < best) begin
            best = f;
            bx = x;
            by = y;
            have = 1;
          end
        end
      end
      if (!have) return;
      c = by * GW + bx;
      done_bit[c] = 1;
      // Relax the eight neighbors; corners may be cut.
      for (int ox = -1; ox <= 1; ox++) begin
        for (int oy = -1; oy <= 1; oy++) begin
          if (ox == 0 && oy == 0) continue;
          nx = int'(bx) + ox;
          ny = int'(by) + oy;
          if (nx < 0 || ny < 0 || nx >= GW || ny >= GH) continue;
          n = ny * GW + nx;
          if (!walk_bit[n] || done_bit[n]) continue;
          nc = g_cost[c] + ((ox == 0 || oy == 0) ? 10 : 14);
          if (nc > NoCost) nc = NoCost;
          if (nc < g_cost[n]) begin
            g_cost[n] = nc;
            parent[n] = c;
          end
        end
      end
    end
    if (!done_bit[target]) return;
    count = 0;
    cur = target;
    while (cur != start && count < CELLS) begin
      cur = parent[cur % CELLS];
      count++;
    end
    if (cur != start || count > 4095) return;
    cur = target;
    for (int k = 0; k < count; k++) begin
      route[(count - 1 - k) % 4096] = cur;
      cur = parent[cur % CELLS];
    end
    route_len = count;
    route_ok  = 1;
  endfunction

  // Apply one request to the model and return the result it should give.
  function automatic gasp_pkg::res_t apply_request(gasp_pkg::req_t r);
    gasp_pkg::res_t o;
    int unsigned c;
    bit ok;
    if (r.func == gasp_pkg::FUNC_WRITE) begin
      if (r.cell_x < GW && r.cell_y < GH) walk_bit[r.cell_y * GW + r.cell_x] = r.walkable;
    end else if (r.func == gasp_pkg::FUNC_SRCH) begin
      find_route(r.cell_x, r.cell_y, r.target_x, r.target_y);
    end
    ok = route_ok && (r.path_index < route_len);
    o = '0;
    o.found       = route_ok;
    o.path_length = route_len[11:0];
    o.step_valid  = ok;
    if (ok) begin
      c = route[r.path_index];
      o.step_x = 6'((c % GW) & 63);
      o.step_y = 6'(((c / GW) % GH) & 63);
    end
    return o;
  endfunction

  // Track register writes, predict accepted requests, compare results.
  always @(posedge clk) begin
    gasp_pkg::res_t want;
    if (!rst_n) begin
      for (int k = 0; k < CELLS; k++) walk_bit[k] = 0;
      route_ok   = 0;
      route_len  = 0;
      heur_sel   = gasp_pkg::HEUR_MAN;
      fail_count = 0;
      want_q.delete();
    end else begin
      if (cfg_we) heur_sel = cfg_wdata;
      if (in_valid && in_ready) want_q = {want_q, apply_request(in_data)};
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = want_q.pop_front();
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data.found);
            fail_count++;
          end
          if (out_data.path_length !== want.path_length) begin
            $error("path_length: expected %0d, got %0d", want.path_length,
                   out_data.path_length);
            fail_count++;
          end
          if (out_data.step_x !== want.step_x) begin
            $error("step_x: expected %0d, got %0d", want.step_x, out_data.step_x);
            fail_count++;
          end
          if (out_data.step_y !== want.step_y) begin
            $error("step_y: expected %0d, got %0d", want.step_y, out_data.step_y);
            fail_count++;
          end
          if (out_data.step_valid !== want.step_valid) begin
            $error("step_valid: expected %0d, got %0d", want.step_valid,
                   out_data.step_valid);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Top of the grid A* path search testbench: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on gasp_pkg, the core and the checker.
module tb_top;

  localparam int GRID_W = 8;
  localparam int GRID_H = 8;
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  gasp_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gasp_pkg::res_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;
  int pending;
  int fail_count;
  int burst_left = 4;

  grid_astar_path_search_core #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  gasp_route_checker #(
    .GW(GRID_W),
    .GH(GRID_H)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pending   (pending),
    .fail_count(fail_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    int unsigned cyc;
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      $display("[grid_astar_path_search_core] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, stall-free stretches and one long hold-off
  // early on so that the core backs up and stops taking requests.
  always @(posedge clk) begin
    int unsigned rcv_cyc;
    int unsigned hold_left;
    rcv_cyc++;
    if (rcv_cyc == 200) hold_left = 600;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if ((rcv_cyc / 512) % 2 == 1) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic gasp_pkg::req_t mk_req(logic [1:0] f, int cx, int cy, bit wk,
                                            int tx, int ty, int pi);
    gasp_pkg::req_t r;
    r.func       = f;
    r.cell_x     = 6'(cx);
    r.cell_y     = 6'(cy);
    r.walkable   = wk;
    r.target_x   = 6'(tx);
    r.target_y   = 6'(ty);
    r.path_index = 12'(pi);
    return r;
  endfunction

  // Offer one request and hold it until taken; bursts end in a random gap.
  task automatic send(gasp_pkg::req_t r);
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Change the heuristic only once every result is back.
  task automatic set_heur(logic [1:0] m);
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic int coord(bit wide, int lim);
    return wide ? $urandom_range(0, 63) : $urandom_range(0, lim - 1);
  endfunction

  // One random request; mostly in-grid searches and reads of the last path.
  task automatic send_random();
    int pick;
    bit wide;
    pick = $urandom_range(0, 99);
    wide = ($urandom_range(0, 7) == 0);
    if (pick < 15) begin
      send(mk_req(gasp_pkg::FUNC_WRITE, coord(wide, GRID_W), coord(wide, GRID_H),
                  $urandom_range(0, 3) != 0, $urandom_range(0, 63),
                  $urandom_range(0, 63), $urandom_range(0, 4095)));
    end else if (pick < 45) begin
      send(mk_req(gasp_pkg::FUNC_SRCH, coord(wide, GRID_W), coord(wide, GRID_H),
                  $urandom_range(0, 1), coord(wide, GRID_W), coord(wide, GRID_H),
                  $urandom_range(0, 4095)));
    end else if (pick < 90) begin
      send(mk_req(gasp_pkg::FUNC_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 63),
                  wide ? $urandom_range(0, 4095) : $urandom_range(0, 12)));
    end else begin
      send(mk_req(FUNC_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 4095)));
    end
  endtask

  initial begin
    logic [1:0] modes [5];
    modes = '{gasp_pkg::HEUR_NONE, gasp_pkg::HEUR_DIAG, gasp_pkg::HEUR_EUC,
              gasp_pkg::HEUR_MAN, gasp_pkg::HEUR_EUC};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty map, start on target, out-of-grid cases, a short route.
    send(mk_req(gasp_pkg::FUNC_SRCH, 0, 0, 0, 2, 2, 0));
    send(mk_req(gasp_pkg::FUNC_SRCH, 5, 5, 0, 5, 5, 0));
    send(mk_req(gasp_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0));
    send(mk_req(gasp_pkg::FUNC_WRITE, 63, 63, 1, 0, 0, 0));
    send(mk_req(gasp_pkg::FUNC_WRITE, 0, 0, 1, 0, 0, 0));
    send(mk_req(gasp_pkg::FUNC_WRITE, 1, 0, 1, 0, 0, 0));
    send(mk_req(gasp_pkg::FUNC_WRITE, 2, 0, 1, 0, 0, 0));
    send(mk_req(gasp_pkg::FUNC_WRITE, 3, 1, 1, 0, 0, 0));
    send(mk_req(gasp_pkg::FUNC_WRITE, 3, 2, 1, 0, 0, 0));
    send(mk_req(gasp_pkg::FUNC_WRITE, 2, 3, 1, 0, 0, 0));
    send(mk_req(gasp_pkg::FUNC_WRITE, 1, 0, 0, 0, 0, 0));
    send(mk_req(gasp_pkg::FUNC_WRITE, 1, 0, 1, 0, 0, 0));
    send(mk_req(gasp_pkg::FUNC_SRCH, 0, 0, 0, 2, 3, 0));
    send(mk_req(gasp_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0));
    send(mk_req(gasp_pkg::FUNC_READ, 0, 0, 0, 0, 0, 1));
    send(mk_req(gasp_pkg::FUNC_READ, 0, 0, 0, 0, 0, 2));
    send(mk_req(gasp_pkg::FUNC_READ, 63, 63, 1, 63, 63, 4095));
    send(mk_req(FUNC_NOP, 63, 63, 1, 63, 63, 4095));
    send(mk_req(gasp_pkg::FUNC_READ, 0, 0, 0, 0, 0, 1));
    send(mk_req(gasp_pkg::FUNC_SRCH, 0, 0, 0, 63, 0, 0));
    send(mk_req(gasp_pkg::FUNC_SRCH, 0, 0, 0, GRID_W - 1, GRID_H - 1, 0));
    send(mk_req(gasp_pkg::FUNC_SRCH, 2, 3, 0, 0, 0, 0));
    send(mk_req(gasp_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0));

    // Open most of the map so that searches go somewhere.
    for (int x = 0; x < GRID_W; x++) begin
      for (int y = 0; y < GRID_H; y++) begin
        send(mk_req(gasp_pkg::FUNC_WRITE, x, y, ($urandom_range(0, 4) != 0) ||
                    (x == 0 && y == 0) || (x == GRID_W - 1 && y == GRID_H - 1),
                    $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 4095)));
      end
    end
    send(mk_req(gasp_pkg::FUNC_SRCH, 0, 0, 0, GRID_W - 1, GRID_H - 1, 0));

    // Random phases, one per entry of the mode list.
    foreach (modes[m]) begin
      set_heur(modes[m]);
      send(mk_req(gasp_pkg::FUNC_SRCH, 0, 0, 0, GRID_W - 1, GRID_H - 1, 0));
      repeat (3) send_random();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("[grid_astar_path_search_core] OK");
    end else begin
      $display("[grid_astar_path_search_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/gasp_pkg.sv
rtl/gasp_heur.sv
rtl/grid_astar_path_search_core.sv
sim/gasp_route_checker.sv
sim/tb_top.sv
